### hw/rtl/mvm_pkg.sv
// Package for the multi-voice mixer: request codes, sizes and the per-voice entry layout.
// No dependencies.
`default_nettype none
package mvm_pkg;
    localparam int NUM_VOICES = 16;
    localparam int MAX_BLOCK  = 4096;
    localparam int VIDX_W     = 4;

    localparam logic [2:0] REQ_START = 3'd0;
    localparam logic [2:0] REQ_STOP  = 3'd1;
    localparam logic [2:0] REQ_BEGIN = 3'd2;
    localparam logic [2:0] REQ_SMP   = 3'd3;
    localparam logic [2:0] REQ_END   = 3'd4;

    localparam logic [15:0] UNITY   = 16'd32768;
    localparam logic [23:0] POS_MAX = 24'hFFFFFF;

    typedef struct packed {
        logic        on;
        logic        loops;
        logic        fading;
        logic        mixing;
        logic [15:0] volume;
        logic [15:0] flen;
        logic [15:0] felap;
        logic [15:0] gain;
        logic [23:0] pos;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);
endpackage
`default_nettype wire

### hw/rtl/mvm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none
module mvm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### hw/rtl/multi_voice_audio_mixer_with_fade.sv
// Each item passes ST_LOAD and ST_CALC on to ST_DONE; a sample of a mixing voice also
// passes ST_MIXB and ST_MIXC, and a block begin of a fading voice passes ST_DIV
// (32-step restoring divider) before ST_DONE; one item in flight.
// The next item is accepted while the previous result still waits on the output; it then
// holds in its last step until the output register frees.
// Reset (aresetn low, synchronous): all voices read as zero through per-entry valid bits,
// accumulator cleared, no result pending.
`default_nettype none
module multi_voice_audio_mixer_with_fade
    import mvm_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [2:0]         s_req_type,
    input  wire logic [3:0]         s_voice,
    input  wire logic [15:0]        s_volume,
    input  wire logic               s_loop_mode,
    input  wire logic               s_force_restart,
    input  wire logic [15:0]        s_fade_time,
    input  wire logic [15:0]        s_elapsed,
    input  wire logic signed [15:0] s_sample_in,
    input  wire logic               s_frame_last,
    input  wire logic [12:0]        s_samples_read,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [15:0]      m_mixed_sample,
    output logic                    m_sample_valid,
    output logic                    m_voice_active,
    output logic [23:0]             m_play_position
);
    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_LOAD = 7'b0000010,
        ST_CALC = 7'b0000100,
        ST_DIV  = 7'b0001000,
        ST_MIXB = 7'b0010000,
        ST_MIXC = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [2:0]         req_reg;
    logic [VIDX_W-1:0]  vidx_reg;
    logic               ok_reg;
    logic [15:0]        vol_reg, fade_reg, elap_reg;
    logic               loop_reg, force_reg, flast_reg;
    logic signed [15:0] smp_reg;
    logic [12:0]        sread_reg;

    entry_t             ent_reg, ent_next;
    logic [31:0]        prod_reg, prod_next;
    logic [15:0]        rem_reg, rem_next;
    logic [15:0]        quot_reg, quot_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [32:0] sprod_reg, sprod_next;
    logic signed [16:0] b_reg, b_next;
    logic signed [18:0] ab_reg, ab_next;
    logic signed [15:0] acc_reg, acc_next;
    logic [NUM_VOICES-1:0] vld_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    logic               fire;
    logic               s_fire;

    // combinational temporaries
    logic [16:0]        fsum;
    logic [15:0]        fsum16;
    logic [16:0]        rem_sh;
    logic               qbit;
    logic signed [16:0] b_w;
    logic signed [33:0] ab_full;
    logic signed [17:0] mix_sum;
    logic signed [19:0] mix_r;
    logic [12:0]        blk_n;
    logic [24:0]        pos_sum;

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign fire    = (state_reg == ST_DONE) && (!m_valid || m_ready);

    mvm_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_VOICES)) u_ram (
        .aclk  (aclk),
        .we    (fire && ok_reg),
        .waddr (vidx_reg),
        .wdata (ENTRY_W'(ent_reg)),
        .raddr (s_voice),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next = state_reg;
        ent_next   = ent_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        sprod_next = sprod_reg;
        b_next     = b_reg;
        ab_next    = ab_reg;
        acc_next   = acc_reg;
        fsum       = {1'b0, ent_reg.felap} + {1'b0, elap_reg};
        fsum16     = fsum[15:0];
        rem_sh     = {rem_reg, prod_reg[31]};
        qbit       = (rem_sh >= {1'b0, ent_reg.flen});
        b_w        = sprod_reg[31:15];
        ab_full    = acc_reg * b_reg;
        mix_sum    = {{2{acc_reg[15]}}, acc_reg} + {b_reg[16], b_reg};
        mix_r      = '0;
        blk_n      = (sread_reg > 13'(MAX_BLOCK)) ? 13'(MAX_BLOCK) : sread_reg;
        pos_sum    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                ent_next   = vld_reg[vidx_reg] ? entry_t'(ram_rdata) : '0;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                state_next = ST_DONE;
                if (ok_reg) begin
                    unique case (req_reg)
                        REQ_START: begin
                            if (!ent_reg.on || force_reg) begin
                                ent_next.on     = 1'b1;
                                ent_next.volume = (vol_reg > UNITY) ? UNITY : vol_reg;
                                ent_next.fading = 1'b0;
                                ent_next.loops  = loop_reg;
                                ent_next.pos    = '0;
                            end
                        end
                        REQ_STOP: begin
                            if (!ent_reg.fading && ent_reg.on) begin
                                ent_next.fading = 1'b1;
                                ent_next.flen   = fade_reg;
                                ent_next.felap  = '0;
                                if (fade_reg == '0) begin
                                    ent_next.on = 1'b0;
                                end
                            end
                        end
                        REQ_BEGIN: begin
                            if (!ent_reg.on) begin
                                ent_next.mixing = 1'b0;
                                ent_next.gain   = '0;
                            end else begin
                                ent_next.mixing = 1'b1;
                                if (ent_reg.fading) begin
                                    if (fsum > {1'b0, ent_reg.flen}) begin
                                        fsum16          = ent_reg.flen;
                                        ent_next.fading = 1'b0;
                                        ent_next.on     = 1'b0;
                                    end
                                    ent_next.felap = fsum16;
                                    if (ent_reg.flen == '0) begin
                                        ent_next.gain = '0;
                                    end else begin
                                        prod_next  = {16'd0, ent_reg.volume} *
                                                     {16'd0, ent_reg.flen - fsum16};
                                        rem_next   = '0;
                                        quot_next  = '0;
                                        cnt_next   = 5'd31;
                                        state_next = ST_DIV;
                                    end
                                end else begin
                                    ent_next.gain = ent_reg.volume;
                                end
                            end
                        end
                        REQ_SMP: begin
                            if (ent_reg.mixing) begin
                                sprod_next = $signed({1'b0, ent_reg.gain}) * smp_reg;
                                state_next = ST_MIXB;
                            end
                        end
                        REQ_END: begin
                            if (ent_reg.mixing) begin
                                pos_sum = {1'b0, ent_reg.pos} + 25'(blk_n);
                                if (blk_n == '0) begin
                                    if (ent_reg.loops) begin
                                        pos_sum = '0;
                                    end else begin
                                        ent_next.on = 1'b0;
                                    end
                                end
                                ent_next.pos    = pos_sum[24] ? POS_MAX : pos_sum[23:0];
                                ent_next.mixing = 1'b0;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_DIV: begin
                // one restoring step per cycle, MSB first
                prod_next = {prod_reg[30:0], 1'b0};
                rem_next  = qbit ? 16'(rem_sh - {1'b0, ent_reg.flen}) : rem_sh[15:0];
                quot_next = {quot_reg[14:0], qbit};
                cnt_next  = cnt_reg - 5'd1;
                if (cnt_reg == '0) begin
                    ent_next.gain = {quot_reg[14:0], qbit};
                    state_next    = ST_DONE;
                end
            end
            ST_MIXB: begin
                b_next     = b_w;
                ab_next    = 19'(0);
                state_next = ST_MIXC;
            end
            ST_MIXC: begin
                ab_next    = ab_full[33:15];
                mix_r      = (mix_sum > 0)
                             ? (20'(mix_sum) - 20'($signed(ab_full[33:15])))
                             : (20'(mix_sum) + 20'($signed(ab_full[33:15])));
                if (mix_r > 20'sd32767) begin
                    acc_next = 16'sh7FFF;
                end else if (mix_r < -20'sd32768) begin
                    acc_next = -16'sd32768;
                end else begin
                    acc_next = mix_r[15:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (fire) begin
                    state_next = ST_IDLE;
                    if (req_reg == REQ_SMP && flast_reg) begin
                        acc_next = '0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            acc_reg   <= '0;
            vld_reg   <= '0;
            m_valid   <= 1'b0;
        end else begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            if (fire && ok_reg) begin
                vld_reg[vidx_reg] <= 1'b1;
            end
            if (fire) begin
                m_valid <= 1'b1;
            end else if (m_ready) begin
                m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg   <= s_req_type;
            vidx_reg  <= s_voice;
            ok_reg    <= ({1'b0, s_voice} < 5'(NUM_VOICES));
            vol_reg   <= s_volume;
            loop_reg  <= s_loop_mode;
            force_reg <= s_force_restart;
            fade_reg  <= s_fade_time;
            elap_reg  <= s_elapsed;
            smp_reg   <= s_sample_in;
            flast_reg <= s_frame_last;
            sread_reg <= s_samples_read;
        end
        ent_reg   <= ent_next;
        prod_reg  <= prod_next;
        rem_reg   <= rem_next;
        quot_reg  <= quot_next;
        cnt_reg   <= cnt_next;
        sprod_reg <= sprod_next;
        b_reg     <= b_next;
        ab_reg    <= ab_next;
        if (fire) begin
            m_sample_valid  <= (req_reg == REQ_SMP) && flast_reg;
            m_mixed_sample  <= ((req_reg == REQ_SMP) && flast_reg) ? acc_reg : '0;
            if (ok_reg && req_reg <= REQ_END) begin
                m_voice_active  <= (req_reg == REQ_BEGIN) ? ent_reg.mixing : ent_reg.on;
                m_play_position <= ent_reg.pos;
            end else begin
                m_voice_active  <= 1'b0;
                m_play_position <= '0;
            end
        end
    end
endmodule
`default_nettype wire

### hw/rtl/mvm_checker.sv
// Port-level checks for the multi-voice mixer, bound to the top level.
// Depends on multi_voice_audio_mixer_with_fade.
`default_nettype none
module mvm_checker (
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic signed [15:0] m_mixed_sample,
    input wire logic               m_sample_valid
);
    // a held result beat keeps its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mixed_sample))
        else $error("result beat dropped or changed while stalled");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_sample_valid |-> m_mixed_sample == 16'sd0)
        else $error("mixed sample nonzero without a completed frame");

    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat taken while an item is in flight");

    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared one cycle after the input beat");

    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

bind multi_voice_audio_mixer_with_fade mvm_checker u_mvm_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_mixed_sample (m_mixed_sample),
    .m_sample_valid (m_sample_valid)
);
`default_nettype wire
